### src/idt_pkg.sv
// ----------------------------------------------------------------------------
// idt_pkg
// Shared types, constants and tables of the date-time to epoch converter.
// ----------------------------------------------------------------------------
package idt_pkg;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } idt_in_t;

  typedef struct packed {
    logic               valid_res;
    logic signed [63:0] epoch_ns;
    logic               precision_lost;
  } idt_res_t;

  // fields of one parsed text handed from front to back
  typedef struct packed {
    logic        parse_ok;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [29:0] frac;
    logic [3:0]  frac_cnt;
    logic        round_up;
    logic        lost;
    logic        has_off;
    logic        off_neg;
    logic [6:0]  off_h;
    logic [6:0]  off_m;
  } idt_rec_t;

  function automatic logic [4:0] month_len(input logic [6:0] m);
    case (m)
      7'd2:                       month_len = 5'd28;
      7'd4, 7'd6, 7'd9, 7'd11:    month_len = 5'd30;
      default:                    month_len = 5'd31;
    endcase
  endfunction

  // days from march 1 to the first of the month
  function automatic logic [8:0] march_days(input logic [6:0] m);
    case (m)
      7'd1:    march_days = 9'd306;
      7'd2:    march_days = 9'd337;
      7'd3:    march_days = 9'd0;
      7'd4:    march_days = 9'd31;
      7'd5:    march_days = 9'd61;
      7'd6:    march_days = 9'd92;
      7'd7:    march_days = 9'd122;
      7'd8:    march_days = 9'd153;
      7'd9:    march_days = 9'd184;
      7'd10:   march_days = 9'd214;
      7'd11:   march_days = 9'd245;
      7'd12:   march_days = 9'd275;
      default: march_days = 9'd0;
    endcase
  endfunction

  // scale of the kept fraction digits up to nanoseconds
  function automatic logic [29:0] frac_scale(input logic [3:0] cnt);
    case (cnt)
      4'd0:    frac_scale = 30'd1000000000;
      4'd1:    frac_scale = 30'd100000000;
      4'd2:    frac_scale = 30'd10000000;
      4'd3:    frac_scale = 30'd1000000;
      4'd4:    frac_scale = 30'd100000;
      4'd5:    frac_scale = 30'd10000;
      4'd6:    frac_scale = 30'd1000;
      4'd7:    frac_scale = 30'd100;
      4'd8:    frac_scale = 30'd10;
      default: frac_scale = 30'd1;
    endcase
  endfunction

endpackage

### src/idt_queue.sv
// ----------------------------------------------------------------------------
// idt_queue
// Small register queue between the parser front and the arithmetic back.
// ----------------------------------------------------------------------------
module idt_queue import idt_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr, rptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr && !full) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd && !empty) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(wr && !full) - CW'(rd && !empty);
    end
  end

endmodule

### src/idt_front.sv
// ----------------------------------------------------------------------------
// idt_front
// Byte parser: checks the text form and collects the date-time fields.
// ----------------------------------------------------------------------------
module idt_front import idt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  idt_in_t  item,
  output logic     full,
  output logic     rec_wr,
  output idt_rec_t rec,
  input  logic     rec_full
);

  typedef enum logic [2:0] {
    PH_FIXED, PH_TZ, PH_FRAC0, PH_FRAC, PH_ZULU, PH_OFFSET
  } phase_t;

  typedef enum logic [2:0] {
    OM_HT, OM_HU, OM_COLON, OM_MT, OM_MU, OM_DONE
  } omode_t;

  typedef struct packed {
    logic [4:0]  pos;
    phase_t      phase;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [29:0] frac;
    logic [3:0]  fcnt;
    logic        round_up;
    logic        lost;
    logic        off_neg;
    logic [2:0]  off_chars;
    logic [6:0]  off_h;
    logic [6:0]  off_m;
    logic        ferr;
    omode_t      omode;
    logic [3:0]  otens;
  } front_state_t;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam front_state_t ST_RESET = '{
    pos: '0, phase: PH_FIXED, year: '0, month: '0, day: '0, hour: '0,
    minute: '0, second: '0, frac: '0, fcnt: '0, round_up: 1'b0, lost: 1'b0,
    off_neg: 1'b0, off_chars: '0, off_h: '0, off_m: '0, ferr: 1'b0,
    omode: OM_HT, otens: '0
  };

  front_state_t st, st_next;
  logic [7:0]   c;
  logic         dg;
  logic [3:0]   d;
  logic         accept;

  assign c      = item.character;
  assign dg     = (c >= CH_ZERO) && (c <= CH_NINE);
  assign d      = 4'(c - CH_ZERO);
  assign full   = rec_full;
  assign accept = push && !full;

  always_comb begin
    st_next = st;
    if (!st.ferr) begin
      case (st.phase)
        PH_FIXED: begin
          if (st.pos == 5'd4 || st.pos == 5'd7) begin
            if (c != CH_DASH) st_next.ferr = 1'b1;
          end else if (st.pos == 5'd10) begin
            if (c != CH_T) st_next.ferr = 1'b1;
          end else if (st.pos == 5'd13 || st.pos == 5'd16) begin
            if (c != CH_COLON) st_next.ferr = 1'b1;
          end else if (!dg) begin
            st_next.ferr = 1'b1;
          end else if (st.pos <= 5'd3) begin
            st_next.year = 14'(st.year * 14'd10) + 14'(d);
          end else if (st.pos <= 5'd6) begin
            st_next.month = 7'(st.month * 7'd10) + 7'(d);
          end else if (st.pos <= 5'd9) begin
            st_next.day = 7'(st.day * 7'd10) + 7'(d);
          end else if (st.pos <= 5'd12) begin
            st_next.hour = 7'(st.hour * 7'd10) + 7'(d);
          end else if (st.pos <= 5'd15) begin
            st_next.minute = 7'(st.minute * 7'd10) + 7'(d);
          end else begin
            st_next.second = 7'(st.second * 7'd10) + 7'(d);
          end
          st_next.pos = st.pos + 5'd1;
          if (st.pos == 5'd18) st_next.phase = PH_TZ;
        end
        PH_TZ: begin
          if (c == CH_DOT || c == CH_COMMA) begin
            st_next.phase = PH_FRAC0;
          end else if (c == CH_Z) begin
            st_next.phase = PH_ZULU;
          end else if (c == CH_PLUS || c == CH_DASH) begin
            st_next.phase   = PH_OFFSET;
            st_next.off_neg = (c == CH_DASH);
          end else begin
            st_next.ferr = 1'b1;
          end
        end
        PH_FRAC0, PH_FRAC: begin
          if (dg) begin
            st_next.phase = PH_FRAC;
            if (st.fcnt < 4'd9) begin
              st_next.frac = 30'(st.frac * 30'd10) + 30'(d);
            end else begin
              if (st.fcnt == 4'd9 && d >= 4'd5) st_next.round_up = 1'b1;
              if (d != 4'd0) st_next.lost = 1'b1;
            end
            if (st.fcnt < 4'd10) st_next.fcnt = st.fcnt + 4'd1;
          end else if (st.phase == PH_FRAC0) begin
            st_next.ferr = 1'b1;
          end else if (c == CH_Z) begin
            st_next.phase = PH_ZULU;
          end else if (c == CH_PLUS || c == CH_DASH) begin
            st_next.phase   = PH_OFFSET;
            st_next.off_neg = (c == CH_DASH);
          end else begin
            st_next.ferr = 1'b1;
          end
        end
        PH_OFFSET: begin
          case (st.omode)
            OM_HT: begin
              if (dg) begin
                st_next.otens = d;
                st_next.omode = OM_HU;
              end else st_next.omode = OM_DONE;
            end
            OM_HU: begin
              if (dg) begin
                st_next.off_h = 7'(st.otens * 7'd10) + 7'(d);
                st_next.omode = OM_COLON;
              end else st_next.omode = OM_DONE;
            end
            OM_COLON: begin
              if (c == CH_COLON) begin
                st_next.omode = OM_MT;
              end else if (dg) begin
                st_next.otens = d;
                st_next.omode = OM_MU;
              end else st_next.omode = OM_DONE;
            end
            OM_MT: begin
              if (dg) begin
                st_next.otens = d;
                st_next.omode = OM_MU;
              end else st_next.omode = OM_DONE;
            end
            OM_MU: begin
              if (dg) st_next.off_m = 7'(st.otens * 7'd10) + 7'(d);
              st_next.omode = OM_DONE;
            end
            default: ;
          endcase
          if (st.off_chars < 3'd7) st_next.off_chars = st.off_chars + 3'd1;
        end
        default: st_next.ferr = 1'b1;
      endcase
    end
  end

  // record built from the state after the final byte
  always_comb begin
    rec.parse_ok = !st_next.ferr && (st_next.pos >= 5'd19) && (st_next.phase != PH_FRAC0)
                   && !(st_next.phase == PH_OFFSET && st_next.off_chars < 3'd5);
    rec.year     = st_next.year;
    rec.month    = st_next.month;
    rec.day      = st_next.day;
    rec.hour     = st_next.hour;
    rec.minute   = st_next.minute;
    rec.second   = st_next.second;
    rec.frac     = st_next.frac;
    rec.frac_cnt = st_next.fcnt;
    rec.round_up = st_next.round_up;
    rec.lost     = st_next.lost;
    rec.has_off  = (st_next.phase == PH_OFFSET);
    rec.off_neg  = st_next.off_neg;
    rec.off_h    = st_next.off_h;
    rec.off_m    = st_next.off_m;
  end

  assign rec_wr = accept && item.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else if (accept) begin
      st <= item.last ? ST_RESET : st_next;
    end
  end

endmodule

### src/idt_back.sv
// ----------------------------------------------------------------------------
// idt_back
// Range check, epoch ns arithmetic, one step per cycle; S_F may wait for pop.
// ----------------------------------------------------------------------------
module idt_back import idt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  idt_rec_t q_data,
  input  logic     q_empty,
  output logic     q_rd,
  output idt_res_t result,
  output logic     empty,
  input  logic     pop
);

  typedef enum logic [2:0] {
    S_IDLE, S_A, S_B, S_C, S_D, S_E, S_F
  } state_t;

  state_t             state;
  idt_rec_t           rec;
  logic               ok;
  logic [18:0]        p365;
  logic [3:0]         q100;
  logic signed [20:0] tod;
  logic signed [19:0] days;
  logic signed [35:0] secs;
  logic [29:0]        fracns;
  logic [47:0]        plo;
  logic signed [47:0] phi;
  logic               out_valid;
  idt_res_t           out_reg;

  logic [13:0]        yprime;
  logic [9:0]         t;
  logic               leap;
  logic [4:0]         maxd;
  logic               fields_ok;
  logic [8:0]         doy;
  logic [19:0]        hms, offs;
  logic signed [19:0] days_sum;
  logic signed [63:0] ns;

  always_comb begin
    yprime = rec.year - 14'(rec.month <= 7'd2);
    t      = 10'(yprime - 14'd1600);
    // century years inside the supported range
    leap   = (rec.year[1:0] == 2'b00)
             && !(rec.year == 14'd1700 || rec.year == 14'd1800 || rec.year == 14'd1900
                  || rec.year == 14'd2100 || rec.year == 14'd2200);
    maxd   = (rec.month == 7'd2 && leap) ? 5'd29 : month_len(rec.month);
    fields_ok = (rec.month >= 7'd1) && (rec.month <= 7'd12)
                && (rec.day >= 7'd1) && (rec.day <= 7'(maxd))
                && (rec.hour <= 7'd23) && (rec.minute <= 7'd59) && (rec.second <= 7'd60)
                && (rec.year >= 14'd1678) && (rec.year <= 14'd2261);
    doy    = march_days(rec.month) + 9'(rec.day) - 9'd1;
    hms    = 20'(rec.hour) * 20'd3600 + 20'(rec.minute) * 20'd60 + 20'(rec.second);
    offs   = 20'(rec.off_h) * 20'd3600 + 20'(rec.off_m) * 20'd60;
    days_sum = $signed({1'b0, p365}) + $signed({12'b0, t[9:2]}) - $signed({16'b0, q100})
               + $signed({18'b0, q100[3:2]}) + $signed({11'b0, doy}) - 20'sd135080;
    ns = $signed({phi[45:0], 18'b0}) + $signed(64'(plo)) + $signed(64'(fracns))
         + $signed(64'(rec.round_up));
  end

  assign q_rd   = (state == S_IDLE) && !q_empty;
  assign empty  = !out_valid;
  assign result = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid && state != S_F) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            rec   <= q_data;
            state <= S_A;
          end
        end
        S_A: begin
          ok    <= rec.parse_ok && fields_ok;
          p365  <= 19'(t) * 19'd365;
          // divide by 100 through reciprocal, exact below 1000
          q100  <= 4'((16'(t) * 16'd41) >> 12);
          if (!rec.has_off) tod <= $signed({1'b0, hms});
          else if (rec.off_neg) tod <= $signed({1'b0, hms}) + $signed({1'b0, offs});
          else tod <= $signed({1'b0, hms}) - $signed({1'b0, offs});
          state <= S_B;
        end
        S_B: begin
          days   <= days_sum;
          fracns <= 30'(60'(rec.frac) * 60'(frac_scale(rec.frac_cnt)));
          state  <= S_C;
        end
        S_C: begin
          secs  <= 36'(36'(days) * 36'sd86400);
          state <= S_D;
        end
        S_D: begin
          secs  <= secs + 36'(tod);
          state <= S_E;
        end
        S_E: begin
          plo   <= 48'(secs[17:0]) * 48'd1000000000;
          phi   <= 48'($signed(secs[35:18])) * 48'sd1000000000;
          state <= S_F;
        end
        S_F: begin
          if (!out_valid || pop) begin
            out_valid              <= 1'b1;
            out_reg.valid_res      <= ok;
            out_reg.epoch_ns       <= ok ? ns : 64'sd0;
            out_reg.precision_lost <= ok && rec.lost;
            state                  <= S_IDLE;
          end else if (pop && out_valid) begin
            out_valid <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_reg.valid_res |-> out_reg.epoch_ns == 64'sd0 && !out_reg.precision_lost)
    else $error("invalid result carries nonzero payload");

  a_start: assert property (@(posedge clk) disable iff (rst)
    q_rd |=> state == S_A)
    else $error("queue read did not start a conversion");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop |=> out_valid && $stable(out_reg))
    else $error("waiting result changed before transfer");

endmodule

### src/iso8601_datetime_to_epoch_ns_unit.sv
// ----------------------------------------------------------------------------
// iso8601_datetime_to_epoch_ns_unit
// Streams date-time text bytes and returns validity and epoch nanoseconds.
// ----------------------------------------------------------------------------
// Flow: the final byte writes the record to the queue; the back end steps it
//   through S_A to S_F. Throughput: one byte per cycle while full is low;
//   the back end takes one text at a time; it and the queue limit short texts.
// Reset: synchronous rst clears the parser state, the queue and result valid.
module iso8601_datetime_to_epoch_ns_unit import idt_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  idt_in_t  item,
  output logic     full,
  output logic     empty,
  input  logic     pop,
  output idt_res_t result
);

  idt_rec_t rec_w, rec_r;
  logic     rec_wr, q_full, q_rd, q_empty;

  idt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .rec_wr   (rec_wr),
    .rec      (rec_w),
    .rec_full (q_full)
  );

  idt_queue #(
    .WIDTH ($bits(idt_rec_t)),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (rec_wr),
    .wdata (rec_w),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (rec_r),
    .empty (q_empty)
  );

  idt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (rec_r),
    .q_empty (q_empty),
    .q_rd    (q_rd),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule

### dv/idt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// idt_checker
// Watches the text and result channels of the date-time converter, parses the
// accepted bytes, computes the expected epoch nanoseconds and compares them
// with every popped result.
// ----------------------------------------------------------------------------
module idt_checker import idt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  idt_in_t  item,
  input  logic     full,
  input  logic     empty,
  input  logic     pop,
  input  idt_res_t result,
  output int       fail_count,
  output int       pending
);

  typedef enum logic [2:0] {
    P_FIXED, P_TZ, P_FRAC0, P_FRAC, P_ZULU, P_OFFSET
  } phase_e;

  typedef enum logic [2:0] {
    O_HT, O_HU, O_COLON, O_MT, O_MU, O_DONE
  } off_mode_e;

  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  int unsigned pos, yr, mo, dy, hr, mi, sc, frac, frac_n, offc, off_h, off_m, tens;
  bit rnd, lost, off_neg, bad;
  phase_e ph;
  off_mode_e om;
  idt_res_t epoch_queue[$];

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic longint days_from_civil(longint y, longint m, longint d);
    longint era, yoe, doy, doe;
    if (m <= 2) y -= 1;
    era = y / 400;
    yoe = y - era * 400;
    doy = (153 * (m + (m > 2 ? -3 : 9)) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  task automatic clear_parse();
    pos = 0; ph = P_FIXED; yr = 0; mo = 0; dy = 0; hr = 0; mi = 0; sc = 0;
    frac = 0; frac_n = 0; rnd = 0; lost = 0; off_neg = 0; offc = 0;
    off_h = 0; off_m = 0; bad = 0; om = O_HT; tens = 0;
  endtask

  task automatic zone_begin(logic [7:0] c);
    if (c == CH_Z) ph = P_ZULU;
    else if (c == CH_PLUS || c == CH_DASH) begin
      ph = P_OFFSET;
      off_neg = (c == CH_DASH);
    end else bad = 1;
  endtask

  task automatic parse_byte(logic [7:0] c);
    int unsigned d;
    bit dg;
    d = c - CH_ZERO;
    dg = is_digit(c);
    if (bad) return;
    case (ph)
      P_FIXED: begin
        if (pos == 4 || pos == 7) begin
          if (c != CH_DASH) bad = 1;
        end else if (pos == 10) begin
          if (c != CH_T) bad = 1;
        end else if (pos == 13 || pos == 16) begin
          if (c != CH_COLON) bad = 1;
        end else if (!dg) bad = 1;
        else if (pos <= 3) yr = yr * 10 + d;
        else if (pos <= 6) mo = mo * 10 + d;
        else if (pos <= 9) dy = dy * 10 + d;
        else if (pos <= 12) hr = hr * 10 + d;
        else if (pos <= 15) mi = mi * 10 + d;
        else sc = sc * 10 + d;
        pos++;
        if (pos == 19) ph = P_TZ;
      end
      P_TZ: begin
        if (c == CH_DOT || c == CH_COMMA) ph = P_FRAC0;
        else zone_begin(c);
      end
      P_FRAC0, P_FRAC: begin
        if (dg) begin
          ph = P_FRAC;
          if (frac_n < 9) frac = frac * 10 + d;
          else begin
            if (frac_n == 9 && d >= 5) rnd = 1;
            if (d != 0) lost = 1;
          end
          if (frac_n < 10) frac_n++;
        end else if (ph == P_FRAC0) bad = 1;
        else zone_begin(c);
      end
      P_OFFSET: begin
        case (om)
          O_HT: if (dg) begin tens = d; om = O_HU; end else om = O_DONE;
          O_HU: if (dg) begin off_h = tens * 10 + d; om = O_COLON; end else om = O_DONE;
          O_COLON: begin
            if (c == CH_COLON) om = O_MT;
            else if (dg) begin tens = d; om = O_MU; end
            else om = O_DONE;
          end
          O_MT: if (dg) begin tens = d; om = O_MU; end else om = O_DONE;
          O_MU: begin
            if (dg) off_m = tens * 10 + d;
            om = O_DONE;
          end
          default: ;
        endcase
        if (offc < 7) offc++;
      end
      default: bad = 1;
    endcase
  endtask

  function automatic bit fields_legal();
    int unsigned maxd;
    bit leap;
    if (mo < 1 || mo > 12) return 0;
    case (mo)
      2: maxd = 28;
      4, 6, 9, 11: maxd = 30;
      default: maxd = 31;
    endcase
    leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    if (mo == 2 && leap) maxd = 29;
    if (dy < 1 || dy > maxd) return 0;
    if (hr > 23 || mi > 59 || sc > 60) return 0;
    return yr >= 1678 && yr <= 2261;
  endfunction

  function automatic idt_res_t finish_text();
    idt_res_t r;
    longint ns, fr, off;
    bit ok;
    ok = !bad && pos >= 19 && ph != P_FRAC0 && !(ph == P_OFFSET && offc < 5)
         && fields_legal();
    r = '0;
    r.valid_res = ok;
    if (ok) begin
      fr = frac;
      for (int unsigned k = frac_n; k < 9; k++) fr *= 10;
      ns = (days_from_civil(yr, mo, dy) * 86400 + hr * 3600 + mi * 60 + sc)
           * 64'sd1000000000 + fr + rnd;
      if (ph == P_OFFSET) begin
        off = (longint'(off_h) * 3600 + off_m * 60) * 64'sd1000000000;
        ns = off_neg ? ns + off : ns - off;
      end
      r.epoch_ns = ns;
      r.precision_lost = lost;
    end
    return r;
  endfunction

  assign pending = epoch_queue.size();

  always @(posedge clk) begin
    idt_res_t want;
    int errs;
    errs = 0;
    if (rst) begin
      clear_parse();
      epoch_queue.delete();
      fail_count <= 0;
    end else begin
      if (push && !full) begin
        parse_byte(item.character);
        if (item.last) begin
          epoch_queue.push_back(finish_text());
          clear_parse();
        end
      end
      if (pop && !empty) begin
        if (epoch_queue.size() == 0) begin
          $error("result transfer with nothing expected");
          errs++;
        end else begin
          want = epoch_queue.pop_front();
          if (result.valid_res !== want.valid_res) begin
            $error("valid_res: expected %0b actual %0b", want.valid_res, result.valid_res);
            errs++;
          end
          if (result.epoch_ns !== want.epoch_ns) begin
            $error("epoch_ns: expected %0d actual %0d", want.epoch_ns, result.epoch_ns);
            errs++;
          end
          if (result.precision_lost !== want.precision_lost) begin
            $error("precision_lost: expected %0b actual %0b",
                   want.precision_lost, result.precision_lost);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Feeds date-time texts, mostly well formed with random fields, fractions and
// zones, plus broken and noisy ones, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb;
  import idt_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic     clk = 0;
  logic     rst = 1;
  logic     push = 0;
  idt_in_t  item = '0;
  logic     full, empty;
  logic     pop = 0;
  idt_res_t result;
  int       fail_count, pending;
  int       idle_cycles = 0;
  bit       feed_done = 0;
  bit       hold_off = 0;
  bit       held = 0;

  byte unsigned text_bytes[$];

  always #5 clk = ~clk;

  iso8601_datetime_to_epoch_ns_unit u_dut (
    .clk(clk), .rst(rst), .push(push), .item(item), .full(full),
    .empty(empty), .pop(pop), .result(result)
  );

  idt_checker u_chk (
    .clk(clk), .rst(rst), .push(push), .item(item), .full(full),
    .empty(empty), .pop(pop), .result(result),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  task automatic add_num(int unsigned v, int n);
    for (int i = n - 1; i >= 0; i--) text_bytes.push_back(8'("0" + (v / (10 ** i)) % 10));
  endtask

  task automatic build_date(int unsigned y, mo, d, h, mi, s);
    add_num(y, 4); text_bytes.push_back("-"); add_num(mo, 2); text_bytes.push_back("-");
    add_num(d, 2); text_bytes.push_back("T"); add_num(h, 2); text_bytes.push_back(":");
    add_num(mi, 2); text_bytes.push_back(":"); add_num(s, 2);
  endtask

  task automatic build_text(string s);
    for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
  endtask

  task automatic build_random();
    int unsigned k;
    text_bytes.delete();
    k = $urandom_range(0, 99);
    if (k < 80) begin
      build_date($urandom_range(0, 9) == 0 ? $urandom_range(1600, 2400)
                                           : $urandom_range(1678, 2261),
                 $urandom_range(0, 9) == 0 ? $urandom_range(0, 13) : $urandom_range(1, 12),
                 $urandom_range(0, 9) == 0 ? $urandom_range(0, 32) : $urandom_range(1, 28),
                 $urandom_range(0, 24), $urandom_range(0, 60), $urandom_range(0, 61));
      if ($urandom_range(0, 1)) begin
        text_bytes.push_back($urandom_range(0, 1) ? "." : ",");
        repeat ($urandom_range(0, 13)) text_bytes.push_back(8'("0" + $urandom_range(0, 9)));
      end
      case ($urandom_range(0, 3))
        0: ;
        1: text_bytes.push_back("Z");
        default: begin
          text_bytes.push_back($urandom_range(0, 1) ? "+" : "-");
          add_num($urandom_range(0, 99), 2);
          if ($urandom_range(0, 1)) text_bytes.push_back(":");
          add_num($urandom_range(0, 99), 2);
          if ($urandom_range(0, 5) == 0) void'(text_bytes.pop_back());
          if ($urandom_range(0, 5) == 0) text_bytes.push_back(8'($urandom_range(0, 255)));
        end
      endcase
      // corrupt one byte now and then
      if ($urandom_range(0, 9) == 0)
        text_bytes[$urandom_range(0, text_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 19) == 0)
        repeat ($urandom_range(1, 3)) void'(text_bytes.pop_back());
    end else begin
      repeat ($urandom_range(1, 30)) text_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_text();
    for (int i = 0; i < text_bytes.size(); i++) begin
      repeat (gap_len()) begin
        push <= 0;
        @(posedge clk);
      end
      push <= 1;
      item.character <= text_bytes[i];
      item.last <= (i == text_bytes.size() - 1);
      @(posedge clk);
      while (full) @(posedge clk);
    end
    push <= 0;
  endtask

  // receiver side
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off && !held) begin
        pop <= 0;
        repeat (300) @(posedge clk);
        held = 1;
      end
      repeat (gap_len()) begin
        pop <= 0;
        @(posedge clk);
      end
      pop <= 1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    string directed[$];
    directed = '{"1970-01-01T00:00:00", "1678-01-01T00:00:00Z", "2261-12-31T23:59:60",
                 "1677-12-31T23:59:59", "2262-01-01T00:00:00", "2000-02-29T12:00:00",
                 "1900-02-29T00:00:00", "2024-02-29T00:00:00.5", "2024-13-01T00:00:00",
                 "2024-04-31T00:00:00", "2024-01-01T24:00:00", "2024-01-01T00:60:00",
                 "2024-01-01T00:00:61", "2024-01-01T00:00:00.123456789",
                 "2024-01-01T00:00:00,1234567895", "2024-01-01T00:00:00.9999999999",
                 "2024-01-01T00:00:00.0000000001Z", "2024-01-01T00:00:00.",
                 "2024-01-01T00:00:00+05:30", "2024-01-01T00:00:00-0930",
                 "2024-01-01T00:00:00+05", "2024-01-01T00:00:00+ab:cd",
                 "2024-01-01T00:00:00ZZ", "2024-01-01X00:00:00", "2024-01-01"};
    repeat (7) @(posedge clk);
    rst <= 0;
    foreach (directed[i]) begin
      text_bytes.delete();
      build_text(directed[i]);
      send_text();
    end
    text_bytes.delete();
    text_bytes.push_back(8'hff);
    text_bytes.push_back(8'h00);
    send_text();
    hold_off = 1;
    // roughly 23 bytes per random text, about 1400 bytes in all
    repeat (60) begin
      build_random();
      send_text();
    end
    feed_done = 1;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (idle_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
      if (feed_done && pending == 0) begin
        repeat (20) @(posedge clk);
        if (fail_count == 0 && empty) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule

### files.f
src/idt_pkg.sv
src/idt_queue.sv
src/idt_front.sv
src/idt_back.sv
src/iso8601_datetime_to_epoch_ns_unit.sv
dv/idt_checker.sv
dv/tb.sv
